[src/lkv_pkg.sv]
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

endpackage

[src/lru_key_value_cache.sv]
// an item passes the key scan (S_SCAN), the decision (S_DECIDE), the rank update (S_UPDATE)
// and the output register (S_OUT); a get miss skips the rank update
// throughput: one item at a time; the key scan and the rank update each walk the
// memories one entry per cycle, and a new item is accepted only in S_IDLE, once the last result is loaded
// reset: rst_n synchronous active low; valid bits and entry count clear at once,
// capacity returns to 16, key/value/rank memories are not cleared
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data,   // capacity
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,                 // key[31:0], value[63:32]
  input  logic [0:0]  in_tuser,                 // command[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,                // read_value[31:0]
  output logic [1:0]  out_tuser                 // found[0], evicted[1]
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;
  localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES);
  localparam logic [EW-1:0] ENTRIES_E = EW'(ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_UPDATE, S_OUT} state_t;

  logic [lkv_pkg::KEY_W-1:0] key_mem  [ENTRIES];
  logic [lkv_pkg::VAL_W-1:0] val_mem  [ENTRIES];
  logic [IW-1:0]             rank_mem [ENTRIES];

  logic [lkv_pkg::KEY_W-1:0] key_q;
  logic [lkv_pkg::VAL_W-1:0] val_q;
  logic [IW-1:0]             rank_q;

  state_t                    state_r;
  logic [ENTRIES-1:0]        valid_r;
  logic [CW-1:0]             count_r;
  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic [CW-1:0]             cnt_r;

  logic                      cmd_r;
  logic [lkv_pkg::KEY_W-1:0] key_r;
  logic [lkv_pkg::VAL_W-1:0] val_r;

  logic                      hit_r;
  logic [IW-1:0]             hit_idx_r;
  logic [IW-1:0]             hit_rank_r;
  logic [lkv_pkg::VAL_W-1:0] hit_val_r;
  logic                      have_max_r;
  logic [IW-1:0]             max_idx_r;
  logic [IW-1:0]             max_rank_r;
  logic                      have_free_r;
  logic [IW-1:0]             free_idx_r;

  logic [IW-1:0]             slot_r;
  logic [IW-1:0]             limit_r;
  logic                      all_inc_r;

  logic                      res_found_r;
  logic                      res_evicted_r;
  logic [lkv_pkg::VAL_W-1:0] res_value_r;

  logic                      out_tvalid_r;
  logic [31:0]               out_tdata_r;
  logic [1:0]                out_tuser_r;

  logic [IW-1:0]             rd_addr;
  logic [IW-1:0]             cur_idx;
  logic [CW-1:0]             cnt_m1;
  logic                      cur_valid;
  logic [EW-1:0]             cap_e;
  logic [EW-1:0]             eff_cap;
  logic [EW-1:0]             count_e;
  logic                      do_evict;
  logic [IW-1:0]             ins_slot;
  logic                      kv_we;
  logic                      key_we;
  logic [IW-1:0]             kv_waddr;
  logic [lkv_pkg::VAL_W-1:0] kv_wval;
  logic                      rank_we;
  logic [IW-1:0]             rank_wdata;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign rd_addr   = cnt_r[IW-1:0];
  assign cnt_m1    = cnt_r - CW'(1);
  assign cur_idx   = cnt_m1[IW-1:0];
  assign cur_valid = valid_r[cur_idx];

  // effective capacity clamped to 1..ENTRIES, eviction decision and insert slot
  always_comb begin
    cap_e   = EW'(cap_r);
    count_e = EW'(count_r);
    if (cap_e == '0) begin
      eff_cap = EW'(1);
    end else if (cap_e > ENTRIES_E) begin
      eff_cap = ENTRIES_E;
    end else begin
      eff_cap = cap_e;
    end
    do_evict = (count_e >= eff_cap) && (count_r != '0);
    ins_slot = do_evict ? max_idx_r : free_idx_r;
  end

  // memory write controls
  always_comb begin
    kv_we    = 1'b0;
    key_we   = 1'b0;
    kv_waddr = hit_idx_r;
    kv_wval  = val_r;
    if (state_r == S_DECIDE && cmd_r == lkv_pkg::CMD_PUT) begin
      kv_we = 1'b1;
      if (!hit_r) begin
        key_we   = 1'b1;
        kv_waddr = ins_slot;
      end
    end
    rank_we = (state_r == S_UPDATE) && (cnt_r != '0);
    if (cur_idx == slot_r) begin
      rank_wdata = '0;
    end else if (cur_valid && (all_inc_r || rank_q < limit_r)) begin
      rank_wdata = rank_q + IW'(1);
    end else begin
      rank_wdata = rank_q;
    end
  end

  always_ff @(posedge clk) begin
    key_q  <= key_mem[rd_addr];
    val_q  <= val_mem[rd_addr];
    rank_q <= rank_mem[rd_addr];
    if (key_we) begin
      key_mem[kv_waddr] <= key_r;
    end
    if (kv_we) begin
      val_mem[kv_waddr] <= kv_wval;
    end
    if (rank_we) begin
      rank_mem[cur_idx] <= rank_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      count_r      <= '0;
      cap_r        <= lkv_pkg::CAP_RESET;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r       <= in_tuser[0];
            key_r       <= in_tdata[31:0];
            val_r       <= in_tdata[63:32];
            hit_r       <= 1'b0;
            have_max_r  <= 1'b0;
            have_free_r <= 1'b0;
            max_idx_r   <= '0;
            max_rank_r  <= '0;
            free_idx_r  <= '0;
            cnt_r       <= '0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_r != '0) begin
            if (cur_valid && key_q == key_r && !hit_r) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= cur_idx;
              hit_rank_r <= rank_q;
              hit_val_r  <= val_q;
            end
            if (cur_valid && (!have_max_r || rank_q > max_rank_r)) begin
              have_max_r <= 1'b1;
              max_idx_r  <= cur_idx;
              max_rank_r <= rank_q;
            end
            if (!cur_valid && !have_free_r) begin
              have_free_r <= 1'b1;
              free_idx_r  <= cur_idx;
            end
          end
          if (cnt_r == LAST_CNT) begin
            state_r <= S_DECIDE;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_DECIDE: begin
          cnt_r         <= '0;
          res_evicted_r <= 1'b0;
          res_found_r   <= hit_r;
          if (hit_r) begin
            slot_r    <= hit_idx_r;
            limit_r   <= hit_rank_r;
            all_inc_r <= 1'b0;
            res_value_r <= (cmd_r == lkv_pkg::CMD_PUT) ? val_r : hit_val_r;
            state_r   <= S_UPDATE;
          end else if (cmd_r == lkv_pkg::CMD_GET) begin
            res_value_r <= lkv_pkg::MISS_VALUE;
            state_r     <= S_OUT;
          end else begin
            slot_r           <= ins_slot;
            limit_r          <= '0;
            all_inc_r        <= 1'b1;
            valid_r[ins_slot] <= 1'b1;
            if (!do_evict) begin
              count_r <= count_r + CW'(1);
            end
            res_evicted_r <= do_evict;
            res_value_r   <= val_r;
            state_r       <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (cnt_r == LAST_CNT) begin
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= res_value_r;
            out_tuser_r  <= {res_evicted_r, res_found_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
